// File: src/gstm_pkg.sv
// Shared types and constants for the groove swing time map.
package gstm_pkg;

   // Field widths of the item, result and register ports
   localparam int BEAT_W     = 48;
   localparam int INDEX_W    = 10;
   localparam int LATE_W     = 16;
   localparam int NC_W       = 11;
   localparam int NPB_W      = 4;
   localparam int STRENGTH_W = 15;
   localparam int CSR_W      = 15;
   localparam int CSR_IDX_W  = 2;

   // Lateness scale: a scaled lateness counts in units of 2^-29 slot
   localparam int LATE_SHIFT = 29;
   // Widest note count the hardware supports
   localparam int NC_LIMIT   = 1024;
   // Most slots per beat
   localparam logic [NPB_W-1:0] NPB_MAX = 4'd8;
   localparam logic [NPB_W-1:0] NPB_MIN = 4'd1;
   localparam logic [NC_W-1:0]  NC_MIN  = 11'd2;

   // Lateness clamp, plus and minus one in Q2.14
   localparam logic signed [LATE_W-1:0] LATE_POS = 16'sd16384;
   localparam logic signed [LATE_W-1:0] LATE_NEG = -16'sd16384;
   // Unity strength in unsigned Q1.14
   localparam logic [STRENGTH_W-1:0] STRENGTH_ONE = 15'd16384;

   typedef enum logic [1:0] {
      CMD_MAP   = 2'd0,
      CMD_WRITE = 2'd1,
      CMD_CLEAR = 2'd2,
      CMD_NONE  = 2'd3
   } command_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NOTE_COUNT     = 2'd0,
      CSR_NOTES_PER_BEAT = 2'd1,
      CSR_STRENGTH       = 2'd2,
      CSR_PARAM_MODE     = 2'd3
   } csr_index_type;

endpackage

// File: src/groove_swing_time_map_top.sv
// Groove swing time map: pipelined beat position to swung position mapper.
//
// Give it an item with start while busy is low; it takes one item in every clock cycle.
// A map item (command 0) turns a signed Q32.16 beat position into a swung one: the position
// is multiplied by the slots per beat, the slot index is reduced modulo the note count, the
// latenesses of that slot and the next come from the lateness table (scaled by strength in
// parameterized mode), the position is interpolated between the shifted slot edges, divided
// back by the slots per beat (rounded to nearest, ties upward) and saturated to 48 bits.
// Each result shows on rsp_groovy_time for exactly one cycle with rsp_valid high, and there
// is no way to hold it off, so the receiver must take it then. The pipeline depth is set
// mostly by the two one-bit-per-stage dividers, one reducing the slot index by the note
// count and one dividing the interpolated position by the slots per beat. Write items
// (command 1) store one clamped lateness and clear items (command 2) empty the table; both
// give no result, and neither does command 3. After reset, and after a clear item reaches
// the table, a sweep zeroes the table one entry per cycle; busy stays high from the clear
// item's acceptance until its sweep is done, and after reset until that sweep is done.
// Register writes on the csr_ port take effect at once and are meant for idle times.
module groove_swing_time_map_top
   import gstm_pkg::*;
#(
   parameter int TABLE_DEPTH   = 1024,
   parameter int FRACTION_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [1:0]               req_command,
   input  logic signed [BEAT_W-1:0] req_beat_time,
   input  logic [INDEX_W-1:0]       req_entry_index,
   input  logic signed [LATE_W-1:0] req_entry_value,
   output logic                     rsp_valid,
   output logic signed [BEAT_W-1:0] rsp_groovy_time,
   input  logic                     csr_write_enable,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CSR_W-1:0]         csr_write_data
);

   localparam int F      = FRACTION_BITS;
   localparam int AW     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int NC_MAX = (TABLE_DEPTH < NC_LIMIT) ? TABLE_DEPTH : NC_LIMIT;
   // Position in slots, beat time times up to eight
   localparam int PW     = BEAT_W + NPB_W;
   // Integer slot part of that position
   localparam int SW     = PW - F;
   // Scaled lateness, slot edge distance, fraction product and interpolation sum
   localparam int LP_W   = 2 * LATE_W;
   localparam int D_W    = LP_W + 1;
   localparam int PX_W   = F + 1 + D_W;
   localparam int XW     = PX_W + 1;
   localparam int QW     = XW - LATE_SHIFT;
   // Interpolated position in 2^-F slot, and the signed result before saturation
   localparam int WW     = PW + 2;
   localparam int RW     = WW + 1;
   localparam int TW     = 32;

   localparam logic [AW-1:0] SWEEP_LAST = AW'(TABLE_DEPTH - 1);
   localparam logic signed [D_W-1:0] ONE_LATE =
      {{(D_W-LATE_SHIFT-1){1'b0}}, 1'b1, {LATE_SHIFT{1'b0}}};

   typedef struct packed {
      logic                     valid;
      command_type              cmd;
      logic signed [PW-1:0]     p;
      logic [INDEX_W-1:0]       widx;
      logic signed [LATE_W-1:0] wval;
      logic                     neg;
      logic [SW-1:0]            mag;
      logic [NC_W-1:0]          rem;
   } mod_stage_type;

   typedef struct packed {
      logic              valid;
      logic              neg;
      logic [WW-1:0]     m;
      logic [NPB_W-1:0]  rem;
   } div_stage_type;

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [NC_W-1:0]       note_count_ff;
   logic [NPB_W-1:0]      notes_per_beat_ff;
   logic [STRENGTH_W-1:0] strength_ff;
   logic                  param_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         note_count_ff     <= 11'd16;
         notes_per_beat_ff <= 4'd2;
         strength_ff       <= STRENGTH_ONE;
         param_mode_ff     <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_NOTE_COUNT:     note_count_ff     <= csr_write_data[NC_W-1:0];
            CSR_NOTES_PER_BEAT: notes_per_beat_ff <= csr_write_data[NPB_W-1:0];
            CSR_STRENGTH:       strength_ff       <= csr_write_data[STRENGTH_W-1:0];
            CSR_PARAM_MODE:     param_mode_ff     <= csr_write_data[0];
            default:            param_mode_ff     <= param_mode_ff;
         endcase
      end
   end

   // Clamp the counts into their working ranges
   logic [NC_W-1:0]       nc_eff;
   logic [NPB_W-1:0]      npb_eff;
   logic [STRENGTH_W-1:0] act;

   always_comb begin
      if (note_count_ff < NC_MIN) begin
         nc_eff = NC_MIN;
      end else if (note_count_ff > NC_W'(NC_MAX)) begin
         nc_eff = NC_W'(NC_MAX);
      end else begin
         nc_eff = note_count_ff;
      end
      if (notes_per_beat_ff < NPB_MIN) begin
         npb_eff = NPB_MIN;
      end else if (notes_per_beat_ff > NPB_MAX) begin
         npb_eff = NPB_MAX;
      end else begin
         npb_eff = notes_per_beat_ff;
      end
      act = param_mode_ff ? strength_ff : STRENGTH_ONE;
   end

   // ---------------------------------------------------------------------
   // Acceptance and clear sweep control
   // ---------------------------------------------------------------------
   logic          accept;
   logic          sweep_ff, sweep_in;
   logic [AW-1:0] sweep_addr_ff, sweep_addr_in;
   logic          clear_pend_ff, clear_pend_in;

   // Items at the table stage
   logic                     s3_valid_ff;
   command_type              s3_cmd_ff;
   logic signed [PW-1:0]     s3_p_ff;
   logic [INDEX_W-1:0]       s3_widx_ff;
   logic signed [LATE_W-1:0] s3_wval_ff;
   logic [INDEX_W-1:0]       s3_idx_ff;
   logic [INDEX_W-1:0]       s3_nxt_ff;

   assign accept = start && !busy;
   // Hold off new items while a clear is on its way to the table or the sweep runs
   assign busy   = sweep_ff || clear_pend_ff;

   always_comb begin
      sweep_in      = sweep_ff;
      sweep_addr_in = sweep_addr_ff;
      clear_pend_in = clear_pend_ff;
      if (accept && command_type'(req_command) == CMD_CLEAR) begin
         clear_pend_in = 1'b1;
      end
      if (s3_valid_ff && s3_cmd_ff == CMD_CLEAR) begin
         sweep_in      = 1'b1;
         sweep_addr_in = '0;
         clear_pend_in = 1'b0;
      end else if (sweep_ff) begin
         sweep_addr_in = sweep_addr_ff + 1'b1;
         if (sweep_addr_ff == SWEEP_LAST) begin
            sweep_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff      <= 1'b1;
         sweep_addr_ff <= '0;
         clear_pend_ff <= 1'b0;
      end else begin
         sweep_ff      <= sweep_in;
         sweep_addr_ff <= sweep_addr_in;
         clear_pend_ff <= clear_pend_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 1: capture the item
   // ---------------------------------------------------------------------
   logic                     s1_valid_ff;
   command_type              s1_cmd_ff;
   logic signed [BEAT_W-1:0] s1_beat_ff;
   logic [INDEX_W-1:0]       s1_widx_ff;
   logic signed [LATE_W-1:0] s1_wval_ff;

   always_ff @(posedge clock) begin
      s1_cmd_ff  <= command_type'(req_command);
      s1_beat_ff <= req_beat_time;
      s1_widx_ff <= req_entry_index;
      s1_wval_ff <= req_entry_value;
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 2: position in slots, clamp the lateness to write
   // ---------------------------------------------------------------------
   logic                     s2_valid_ff;
   command_type              s2_cmd_ff;
   logic signed [PW-1:0]     s2_p_ff, s2_p_in;
   logic [INDEX_W-1:0]       s2_widx_ff;
   logic signed [LATE_W-1:0] s2_wval_ff, s2_wval_in;
   logic signed [NPB_W:0]    npb_s;

   always_comb begin
      npb_s   = {1'b0, npb_eff};
      s2_p_in = PW'(s1_beat_ff) * PW'(npb_s);
      if (s1_wval_ff > LATE_POS) begin
         s2_wval_in = LATE_POS;
      end else if (s1_wval_ff < LATE_NEG) begin
         s2_wval_in = LATE_NEG;
      end else begin
         s2_wval_in = s1_wval_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_cmd_ff  <= s1_cmd_ff;
      s2_p_ff    <= s2_p_in;
      s2_widx_ff <= s1_widx_ff;
      s2_wval_ff <= s2_wval_in;
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Slot index modulo note count: sign and magnitude, then one bit per stage
   // ---------------------------------------------------------------------
   mod_stage_type mod_ff [SW+1];
   mod_stage_type mod_in [SW+1];
   logic [SW-1:0] slot;

   always_comb begin
      logic [NC_W-1:0] ext;
      slot              = s2_p_ff[PW-1:F];
      mod_in[0].valid   = s2_valid_ff;
      mod_in[0].cmd     = s2_cmd_ff;
      mod_in[0].p       = s2_p_ff;
      mod_in[0].widx    = s2_widx_ff;
      mod_in[0].wval    = s2_wval_ff;
      mod_in[0].neg     = slot[SW-1];
      mod_in[0].mag     = slot[SW-1] ? (~slot + 1'b1) : slot;
      mod_in[0].rem     = '0;
      for (int k = 0; k < SW; k++) begin
         ext = {mod_ff[k].rem[NC_W-2:0], mod_ff[k].mag[SW-1]};
         if (ext >= nc_eff) begin
            ext = ext - nc_eff;
         end
         mod_in[k+1]     = mod_ff[k];
         mod_in[k+1].mag = {mod_ff[k].mag[SW-2:0], 1'b0};
         mod_in[k+1].rem = ext;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k <= SW; k++) begin
         if (reset) begin
            mod_ff[k] <= '0;
         end else begin
            mod_ff[k] <= mod_in[k];
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stage 3: Euclidean slot index and its successor
   // ---------------------------------------------------------------------
   logic [NC_W-1:0] idx_w, nxt_w;

   always_comb begin
      if (mod_ff[SW].neg && mod_ff[SW].rem != '0) begin
         idx_w = nc_eff - mod_ff[SW].rem;
      end else begin
         idx_w = mod_ff[SW].rem;
      end
      nxt_w = idx_w + NC_W'(1);
      if (nxt_w == nc_eff) begin
         nxt_w = '0;
      end
   end

   always_ff @(posedge clock) begin
      s3_cmd_ff  <= mod_ff[SW].cmd;
      s3_p_ff    <= mod_ff[SW].p;
      s3_widx_ff <= mod_ff[SW].widx;
      s3_wval_ff <= mod_ff[SW].wval;
      s3_idx_ff  <= idx_w[INDEX_W-1:0];
      s3_nxt_ff  <= nxt_w[INDEX_W-1:0];
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= mod_ff[SW].valid;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 4: lateness table, valid bit on top of each entry
   // ---------------------------------------------------------------------
   logic [LATE_W:0]      table_mem [TABLE_DEPTH];
   logic [LATE_W:0]      rd0_ff, rd1_ff;
   logic                 s4_valid_ff;
   logic signed [PW-1:0] s4_p_ff;
   logic                 wr_hit;

   assign wr_hit = s3_valid_ff && s3_cmd_ff == CMD_WRITE
                   && 32'(s3_widx_ff) < 32'(TABLE_DEPTH);

   always_ff @(posedge clock) begin
      if (sweep_ff) begin
         table_mem[sweep_addr_ff] <= '0;
      end else if (wr_hit) begin
         table_mem[AW'(s3_widx_ff)] <= {1'b1, s3_wval_ff};
      end
      rd0_ff <= table_mem[AW'(s3_idx_ff)];
      rd1_ff <= table_mem[AW'(s3_nxt_ff)];
   end

   always_ff @(posedge clock) begin
      s4_p_ff <= s3_p_ff;
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else begin
         // Only map items go on from here
         s4_valid_ff <= s3_valid_ff && s3_cmd_ff == CMD_MAP;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 5: scale latenesses by strength
   // ---------------------------------------------------------------------
   logic                     s5_valid_ff;
   logic signed [PW-1:0]     s5_p_ff;
   logic signed [LP_W-1:0]   s5_l0_ff, s5_l1_ff, l0_in, l1_in;
   logic signed [LATE_W-1:0] late0, late1;
   logic signed [LATE_W-1:0] act_s;

   always_comb begin
      late0 = rd0_ff[LATE_W] ? $signed(rd0_ff[LATE_W-1:0]) : '0;
      late1 = rd1_ff[LATE_W] ? $signed(rd1_ff[LATE_W-1:0]) : '0;
      act_s = {1'b0, act};
      l0_in = LP_W'(late0) * LP_W'(act_s);
      l1_in = LP_W'(late1) * LP_W'(act_s);
   end

   always_ff @(posedge clock) begin
      s5_p_ff  <= s4_p_ff;
      s5_l0_ff <= l0_in;
      s5_l1_ff <= l1_in;
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else begin
         s5_valid_ff <= s4_valid_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 6: distance between the shifted slot edges
   // ---------------------------------------------------------------------
   logic                   s6_valid_ff;
   logic signed [PW-1:0]   s6_p_ff;
   logic signed [LP_W-1:0] s6_l0_ff;
   logic signed [D_W-1:0]  s6_d_ff;

   always_ff @(posedge clock) begin
      s6_p_ff  <= s5_p_ff;
      s6_l0_ff <= s5_l0_ff;
      s6_d_ff  <= ONE_LATE + D_W'(s5_l1_ff) - D_W'(s5_l0_ff);
      if (reset) begin
         s6_valid_ff <= 1'b0;
      end else begin
         s6_valid_ff <= s5_valid_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 7: fraction times edge distance
   // ---------------------------------------------------------------------
   logic                   s7_valid_ff;
   logic signed [PW-1:0]   s7_p_ff;
   logic signed [LP_W-1:0] s7_l0_ff;
   logic signed [PX_W-1:0] s7_prod_ff;
   logic signed [F:0]      frac_s;

   assign frac_s = {1'b0, s6_p_ff[F-1:0]};

   always_ff @(posedge clock) begin
      s7_p_ff    <= s6_p_ff;
      s7_l0_ff   <= s6_l0_ff;
      s7_prod_ff <= PX_W'(frac_s) * PX_W'(s6_d_ff);
      if (reset) begin
         s7_valid_ff <= 1'b0;
      end else begin
         s7_valid_ff <= s6_valid_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 8: interpolate, split into whole and sub-step parts
   // ---------------------------------------------------------------------
   logic                         s8_valid_ff;
   logic signed [PW-1:0]         s8_p_ff;
   logic signed [QW-1:0]         s8_q_ff;
   logic [LATE_SHIFT-1:0]        s8_r_ff;
   logic signed [XW-1:0]         x_w;

   assign x_w = (XW'(s7_l0_ff) <<< F) + XW'(s7_prod_ff);

   always_ff @(posedge clock) begin
      s8_p_ff <= s7_p_ff;
      s8_q_ff <= x_w[XW-1:LATE_SHIFT];
      s8_r_ff <= x_w[LATE_SHIFT-1:0];
      if (reset) begin
         s8_valid_ff <= 1'b0;
      end else begin
         s8_valid_ff <= s7_valid_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 9: add the slot base and the rounding half
   // ---------------------------------------------------------------------
   logic                 s9_valid_ff;
   logic signed [WW-1:0] s9_w_ff, y_w, w_in;
   logic signed [PW-1:0] p_base;
   logic [TW-1:0]        t_w;

   always_comb begin
      p_base = {s8_p_ff[PW-1:F], {F{1'b0}}};
      y_w    = WW'(p_base) + WW'(s8_q_ff);
      t_w    = {{(TW-LATE_SHIFT){1'b0}}, s8_r_ff}
               + {npb_eff, {(TW-NPB_W){1'b0}}};
      w_in   = y_w + WW'(t_w[TW-1:LATE_SHIFT]);
   end

   always_ff @(posedge clock) begin
      s9_w_ff <= w_in;
      if (reset) begin
         s9_valid_ff <= 1'b0;
      end else begin
         s9_valid_ff <= s8_valid_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Floor division by slots per beat: magnitude, then one bit per stage
   // ---------------------------------------------------------------------
   div_stage_type div_ff [WW+1];
   div_stage_type div_in [WW+1];

   always_comb begin
      logic [NPB_W-1:0] ext;
      div_in[0].valid = s9_valid_ff;
      div_in[0].neg   = s9_w_ff[WW-1];
      // Floor of a negative quotient: negate the ceiling of the magnitude
      div_in[0].m     = s9_w_ff[WW-1]
                        ? (~s9_w_ff + 1'b1) + WW'(npb_eff) - WW'(1)
                        : s9_w_ff;
      div_in[0].rem   = '0;
      for (int k = 0; k < WW; k++) begin
         ext = {div_ff[k].rem[NPB_W-2:0], div_ff[k].m[WW-1]};
         div_in[k+1]     = div_ff[k];
         if (ext >= npb_eff) begin
            div_in[k+1].rem = ext - npb_eff;
            div_in[k+1].m   = {div_ff[k].m[WW-2:0], 1'b1};
         end else begin
            div_in[k+1].rem = ext;
            div_in[k+1].m   = {div_ff[k].m[WW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k <= WW; k++) begin
         if (reset) begin
            div_ff[k] <= '0;
         end else begin
            div_ff[k] <= div_in[k];
         end
      end
   end

   // ---------------------------------------------------------------------
   // Output: restore sign, saturate to 48 bits
   // ---------------------------------------------------------------------
   logic                     rsp_valid_ff;
   logic signed [BEAT_W-1:0] rsp_time_ff, rsp_time_in;
   logic signed [RW-1:0]     res_w;
   logic                     top_zero, top_ones;

   always_comb begin
      res_w    = div_ff[WW].neg ? -$signed({1'b0, div_ff[WW].m})
                                :  $signed({1'b0, div_ff[WW].m});
      top_zero = ~|res_w[RW-1:BEAT_W-1];
      top_ones = &res_w[RW-1:BEAT_W-1];
      if (top_zero || top_ones) begin
         rsp_time_in = res_w[BEAT_W-1:0];
      end else if (res_w[RW-1]) begin
         rsp_time_in = {1'b1, {(BEAT_W-1){1'b0}}};
      end else begin
         rsp_time_in = {1'b0, {(BEAT_W-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      rsp_time_ff <= rsp_time_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= div_ff[WW].valid;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_groovy_time = rsp_time_ff;

endmodule

// File: src/gstm_checker.sv
// Port-level checks for the groove swing time map, bound to the top level.
module gstm_checker
   import gstm_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic [1:0] req_command,
   input logic       rsp_valid
);

   // Reset starts the table sweep, so no item may enter straight after it
   a_busy_after_reset: assert property (@(posedge clock) reset |=> busy)
      else $error("busy low after reset");

   // An accepted clear holds off the next item
   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_command == CMD_CLEAR) |=> busy)
      else $error("item accepted right after a clear");

   // Reset drops anything in flight
   a_no_result_after_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result shown after reset");

   // No result while the sweep that reset started is still early
   a_quiet_during_sweep: assert property (@(posedge clock)
      reset ##1 !reset |=> !rsp_valid)
      else $error("result shown during the reset sweep");

endmodule

bind groove_swing_time_map_top gstm_checker u_gstm_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .req_command (req_command),
   .rsp_valid   (rsp_valid)
);

// File: bench/tb_groove_swing_time_map_top.sv
// Self-checking bench for the groove swing time map: its own predictor and a result checker.
module tb_groove_swing_time_map_top;
   import gstm_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   // Allow for the pipeline depth with margin
   localparam int DRAIN_CYCLES = 140;
   localparam longint ONE_LATE = 64'sd1 << LATE_SHIFT;
   localparam longint TIME_ONE = 64'sd1 << 16;
   localparam longint MAX48 = (64'sd1 <<< 47) - 1;
   localparam longint MIN48 = -(64'sd1 <<< 47);

   logic                     clock;
   logic                     reset;
   logic                     start;
   logic                     busy;
   logic [1:0]               req_command;
   logic signed [BEAT_W-1:0] req_beat_time;
   logic [INDEX_W-1:0]       req_entry_index;
   logic signed [LATE_W-1:0] req_entry_value;
   logic                     rsp_valid;
   logic signed [BEAT_W-1:0] rsp_groovy_time;
   logic                     csr_write_enable;
   logic [CSR_IDX_W-1:0]     csr_index;
   logic [CSR_W-1:0]         csr_write_data;

   groove_swing_time_map_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_command      (req_command),
      .req_beat_time    (req_beat_time),
      .req_entry_index  (req_entry_index),
      .req_entry_value  (req_entry_value),
      .rsp_valid        (rsp_valid),
      .rsp_groovy_time  (rsp_groovy_time),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Shadow copy of the registers and the lateness table
   logic [NC_W-1:0]          sh_note_count;
   logic [NPB_W-1:0]         sh_notes_per_beat;
   logic [STRENGTH_W-1:0]    sh_strength;
   logic                     sh_param_mode;
   logic signed [LATE_W-1:0] sh_late [NC_LIMIT];
   bit                       sh_valid [NC_LIMIT];

   // Swung positions still in flight, oldest first
   logic signed [BEAT_W-1:0] pending_groovy [$];
   int                       error_count;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Floor division, as the hardware rounds toward minus infinity
   function automatic longint floor_div(longint a, longint b);
      longint q;
      q = a / b;
      if (a - q * b < 0) q = q - 1;
      return q;
   endfunction

   function automatic longint read_lateness(longint idx);
      if (!sh_valid[idx]) return 0;
      return longint'(sh_late[idx]);
   endfunction

   // Swing one beat position through the shadow table
   function automatic logic signed [BEAT_W-1:0] swing_position(logic signed [BEAT_W-1:0] beat);
      longint b, npb, nc, p, frac, slot, idx, nxt, act, l0, l1, d, x, q, r, y, qy, ry, res;
      b = beat;
      npb = sh_notes_per_beat;
      nc = sh_note_count;
      if (npb < 1) npb = 1;
      if (npb > 8) npb = 8;
      if (nc < 2) nc = 2;
      if (nc > NC_LIMIT) nc = NC_LIMIT;
      p = b * npb;
      frac = p & (TIME_ONE - 1);
      slot = (p - frac) / TIME_ONE;
      idx = slot % nc;
      if (idx < 0) idx = idx + nc;
      nxt = (idx + 1) % nc;
      act = sh_param_mode ? longint'(sh_strength) : 16384;
      l0 = read_lateness(idx) * act;
      l1 = read_lateness(nxt) * act;
      d = ONE_LATE + l1 - l0;
      x = l0 * TIME_ONE + frac * d;
      q = floor_div(x, ONE_LATE);
      r = x - q * ONE_LATE;
      y = slot * TIME_ONE + q;
      qy = floor_div(y, npb);
      ry = y - qy * npb;
      res = qy + floor_div(ry * ONE_LATE + r + npb * (ONE_LATE / 2), npb * ONE_LATE);
      if (res > MAX48) res = MAX48;
      if (res < MIN48) res = MIN48;
      return res[BEAT_W-1:0];
   endfunction

   // Update the shadow state for an accepted item and queue any result
   task automatic predict_item(command_type cmd, logic signed [BEAT_W-1:0] beat,
                               logic [INDEX_W-1:0] index, logic signed [LATE_W-1:0] value);
      logic signed [LATE_W-1:0] clamped;
      case (cmd)
         CMD_MAP: pending_groovy.push_back(swing_position(beat));
         CMD_WRITE: begin
            clamped = value;
            if (value > LATE_POS) clamped = LATE_POS;
            if (value < LATE_NEG) clamped = LATE_NEG;
            sh_late[index] = clamped;
            sh_valid[index] = 1'b1;
         end
         CMD_CLEAR: begin
            foreach (sh_valid[i]) sh_valid[i] = 1'b0;
         end
         default: ;
      endcase
   endtask

   // Present one item and hold it until the block takes it; start stays high afterwards
   task automatic send_item(command_type cmd, logic signed [BEAT_W-1:0] beat,
                            logic [INDEX_W-1:0] index, logic signed [LATE_W-1:0] value);
      start <= 1'b1;
      req_command <= cmd;
      req_beat_time <= beat;
      req_entry_index <= index;
      req_entry_value <= value;
      do @(posedge clock); while (busy);
      predict_item(cmd, beat, index, value);
   endtask

   // Drop start for a random gap: mostly none, a few long ones
   task automatic sender_gap();
      int pick, len;
      pick = $urandom_range(0, 99);
      if (pick < 55) len = 0;
      else if (pick < 90) len = $urandom_range(1, 3);
      else len = $urandom_range(8, 40);
      if (len > 0) begin
         start <= 1'b0;
         repeat (len) @(posedge clock);
      end
   endtask

   // Drop start and wait until every result is in and the pipeline has drained
   task automatic wait_idle();
      start <= 1'b0;
      @(posedge clock);
      while (pending_groovy.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic write_register(csr_index_type idx, logic [CSR_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_NOTE_COUNT:     sh_note_count = data[NC_W-1:0];
         CSR_NOTES_PER_BEAT: sh_notes_per_beat = data[NPB_W-1:0];
         CSR_STRENGTH:       sh_strength = data[STRENGTH_W-1:0];
         default:            sh_param_mode = data[0];
      endcase
   endtask

   task automatic set_config(logic [CSR_W-1:0] nc, logic [CSR_W-1:0] npb,
                             logic [CSR_W-1:0] str, logic [CSR_W-1:0] mode);
      wait_idle();
      write_register(CSR_NOTE_COUNT, nc);
      write_register(CSR_NOTES_PER_BEAT, npb);
      write_register(CSR_STRENGTH, str);
      write_register(CSR_PARAM_MODE, mode);
   endtask

   function automatic logic signed [BEAT_W-1:0] random_beat();
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      // Mostly positions near zero, so slots and wrapping get exercised
      if ($urandom_range(0, 3) != 0) return raw[23:0] - 48'sd8388608;
      return raw[BEAT_W-1:0];
   endfunction

   // One random item: mostly maps and writes, a few clears and ignored commands
   task automatic send_random_item();
      int pick;
      logic [INDEX_W-1:0] index;
      logic [INDEX_W-1:0] any_index;
      logic [LATE_W-1:0]  any_value;
      pick = $urandom_range(0, 99);
      index = INDEX_W'($urandom);
      any_index = INDEX_W'($urandom);
      any_value = LATE_W'($urandom);
      // Keep most writes inside the active note count
      if ($urandom_range(0, 3) != 0 && sh_note_count > 1 && sh_note_count <= NC_LIMIT)
         index = INDEX_W'($urandom_range(0, sh_note_count - 1));
      if (pick < 58) send_item(CMD_MAP, random_beat(), any_index, any_value);
      else if (pick < 95) send_item(CMD_WRITE, random_beat(), index, any_value);
      else if (pick < 97) send_item(CMD_CLEAR, random_beat(), any_index, any_value);
      else send_item(CMD_NONE, random_beat(), any_index, any_value);
      sender_gap();
   endtask

   // Field extremes, clamps, negative wrap, clear and the ignored command
   task automatic test_directed();
      send_item(CMD_MAP, 48'sd0, '0, '0);
      send_item(CMD_WRITE, '0, 10'd0, 16'sd32767);
      send_item(CMD_WRITE, '0, 10'd1, -16'sd32768);
      send_item(CMD_WRITE, '0, 10'd15, 16'sd8192);
      send_item(CMD_WRITE, '0, 10'd1023, -16'sd16384);
      send_item(CMD_MAP, 48'sd32768, '0, '0);
      send_item(CMD_MAP, 48'sd98304, '0, '0);
      send_item(CMD_MAP, -48'sd1, '0, '0);
      send_item(CMD_MAP, -48'sd65536, '0, '0);
      send_item(CMD_MAP, 48'sh7FFF_FFFF_FFFF, '0, '0);
      send_item(CMD_MAP, 48'sh8000_0000_0000, '0, '0);
      send_item(CMD_NONE, 48'sd32768, 10'd2, 16'sd100);
      send_item(CMD_MAP, 48'sd1, '0, '0);
      send_item(CMD_CLEAR, '0, '0, '0);
      send_item(CMD_MAP, 48'sd32768, '0, '0);
      send_item(CMD_WRITE, '0, 10'd3, 16'sd16385);
      send_item(CMD_MAP, 48'sd98304, '0, '0);
      send_item(CMD_MAP, 48'sh7FFF_FFFF_0000, '0, '0);
   endtask

   // Register settings: extremes and out-of-range values that the block clamps
   task automatic test_config_sweep();
      set_config(15'd0, 15'd0, 15'd0, 15'd1);
      repeat (30) send_random_item();
      set_config(15'd1024, 15'd8, 15'd32767, 15'd1);
      repeat (30) send_random_item();
      set_config(15'd2047, 15'd15, 15'd16384, 15'd0);
      repeat (30) send_random_item();
      set_config(15'd2, 15'd1, 15'd8191, 15'd1);
      repeat (30) send_random_item();
   endtask

   // Random settings, random items
   task automatic test_random();
      repeat (4) begin
         set_config(CSR_W'($urandom_range(2, 40)), CSR_W'($urandom_range(1, 8)),
                    CSR_W'($urandom_range(0, 32767)), CSR_W'($urandom_range(0, 1)));
         repeat (140) send_random_item();
      end
   endtask

   // Hold off the sender until the block has emptied, then resume
   task automatic test_pressure();
      repeat (20) send_random_item();
      start <= 1'b0;
      @(posedge clock);
      while (pending_groovy.size() != 0) @(posedge clock);
      repeat (20) send_random_item();
   endtask

   // Compare every strobed result with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_groovy.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %0d", $time,
                     rsp_groovy_time);
            error_count++;
         end else begin
            if (rsp_groovy_time !== pending_groovy[0]) begin
               $display("%0t: groovy_time mismatch, expected %0d, actual %0d", $time,
                        pending_groovy[0], rsp_groovy_time);
               error_count++;
            end
            void'(pending_groovy.pop_front());
         end
      end
   end

   initial begin
      error_count = 0;
      reset = 1'b1;
      start = 1'b0;
      req_command = CMD_MAP;
      req_beat_time = '0;
      req_entry_index = '0;
      req_entry_value = '0;
      csr_write_enable = 1'b0;
      csr_index = CSR_NOTE_COUNT;
      csr_write_data = '0;
      sh_note_count = 11'd16;
      sh_notes_per_beat = 4'd2;
      sh_strength = STRENGTH_ONE;
      sh_param_mode = 1'b0;
      foreach (sh_valid[i]) begin
         sh_valid[i] = 1'b0;
         sh_late[i] = '0;
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_config_sweep();
      test_pressure();
      test_random();

      // Drain what is left in the pipeline
      start <= 1'b0;
      @(posedge clock);
      while (pending_groovy.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_groovy.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // Stop a hung run
   initial begin
      #20ms;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

// File: files.f
src/gstm_pkg.sv
src/groove_swing_time_map_top.sv
src/gstm_checker.sv
bench/tb_groove_swing_time_map_top.sv
